// ===== hdl/hsed_pkg.sv =====
// Shared types and constants for the HTML tag strip / entity decode core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsed_pkg;

    typedef logic [7:0] t_byte;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam t_byte C_LT    = 8'h3C;
    localparam t_byte C_GT    = 8'h3E;
    localparam t_byte C_AMP   = 8'h26;
    localparam t_byte C_SEMI  = 8'h3B;
    localparam t_byte C_HASH  = 8'h23;
    localparam t_byte C_SPACE = 8'h20;
    localparam t_byte C_QUOT  = 8'h22;
    localparam t_byte C_APOS  = 8'h27;
    localparam t_byte C_NUL   = 8'h00;

    localparam logic [15:0] N_LT   = "lt";
    localparam logic [15:0] N_GT   = "gt";
    localparam logic [23:0] N_AMP  = "amp";
    localparam logic [31:0] N_QUOT = "quot";
    localparam logic [31:0] N_APOS = "apos";
    localparam logic [31:0] N_NBSP = "nbsp";

    // controller -> datapath
    typedef struct packed {
        logic feed_in;   // document byte transfer accepted
        logic end_acc;   // end-of-document transfer accepted
        logic replay;    // decoder input comes from the held bytes
        logic rstep;     // decode one held byte
        logic flush;     // push staged result as last
        logic estep;     // emit one held byte at end of document
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic miss;
        logic at_end;
        logic pending;
        logic cnt_zero;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/hsed_in_if.sv =====
// Input channel: valid/ready with request type and document byte.
// Depends on hsed_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hsed_in_if;
    logic             valid;
    logic             ready;
    logic             req_type;
    hsed_pkg::t_byte  in_char;

    modport source (output valid, output req_type, output in_char, input ready);
    modport sink   (input valid, input req_type, input in_char, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsed_out_if.sv =====
// Output channel: valid/ready with one decoded result.
// Depends on hsed_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hsed_out_if;
    logic             valid;
    logic             ready;
    hsed_pkg::t_byte  out_char;
    logic             char_valid;
    logic             doc_end;
    logic             run_last;

    modport source (output valid, output out_char, output char_valid, output doc_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_char, input char_valid, input doc_end,
                    input run_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsed_ctrl.sv =====
// Sequencing state machine: accept, replay of held bytes, flush, end of document.
// Depends on hsed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsed_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_req_type,
    input  hsed_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output hsed_pkg::t_cmd  o_cmd
);
    import hsed_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REPLAY = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_EOD    = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = (r_state == S_IDLE) && i_sts.out_free;
        acc          = i_in_valid && o_in_ready;
        o_cmd.replay = (r_state == S_REPLAY);
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_req_type == REQ_BYTE) begin
                        o_cmd.feed_in = 1'b1;
                        if (i_sts.miss) begin
                            n_state = S_REPLAY;
                        end
                    end else begin
                        o_cmd.end_acc = 1'b1;
                        if (i_sts.pending && !i_sts.cnt_zero) begin
                            n_state = S_EOD;
                        end
                    end
                end
            end
            S_REPLAY: begin
                if (i_sts.out_free) begin
                    o_cmd.rstep = 1'b1;
                    if (!i_sts.miss && i_sts.at_end) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EOD: begin
                if (i_sts.out_free) begin
                    o_cmd.estep = 1'b1;
                    if (i_sts.at_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hsed_dp.sv =====
// Datapath: tag stripper, entity hold buffer and matcher, staging and output register.
// Depends on hsed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsed_dp #(
    parameter int ENTITY_SPAN = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hsed_pkg::t_cmd   i_cmd,
    input  hsed_pkg::t_byte  i_in_char,
    output hsed_pkg::t_sts   o_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output hsed_pkg::t_byte  o_out_char,
    output logic             o_char_valid,
    output logic             o_doc_end,
    output logic             o_run_last
);
    import hsed_pkg::*;

    localparam int CW = $clog2(ENTITY_SPAN + 1);
    localparam int IW = $clog2(ENTITY_SPAN);

    logic          r_inside, r_emitted, r_lws, r_pending;
    logic [CW-1:0] r_count, r_idx, r_len;
    t_byte         r_buf [ENTITY_SPAN];
    t_byte         r_stg;
    logic          r_out_valid;
    t_byte         r_out_char;
    logic          r_out_cv, r_out_de, r_out_last;

    logic          n_inside, n_emitted, n_lws, n_pending;
    logic [CW-1:0] n_count, cnt1;
    logic          s_feed;
    t_byte         s_char, d_char, d_gch, rd_char;
    logic          d_feed, d_gen, d_miss, d_we, upd;
    logic          m_lt, m_gt, m_amp, m_quot, m_apos, m_nbsp;
    logic          out_free, at_end;
    logic          ld, ld_cv, ld_de, ld_last;
    t_byte         ld_char;

    assign rd_char  = r_buf[r_idx[IW-1:0]];
    assign out_free = !r_out_valid || i_out_ready;
    assign at_end   = ((r_idx + CW'(1)) == r_len);
    assign cnt1     = r_count + CW'(1);

    // tag stripper
    always_comb begin
        n_inside  = r_inside;
        n_emitted = r_emitted;
        n_lws     = r_lws;
        s_feed    = 1'b0;
        s_char    = i_in_char;
        if (i_in_char == C_LT) begin
            n_inside = 1'b1;
        end else if (i_in_char == C_GT) begin
            n_inside = 1'b0;
            if (r_emitted && !r_lws) begin
                n_lws  = 1'b1;
                s_feed = 1'b1;
                s_char = C_SPACE;
            end
        end else if (!r_inside) begin
            n_emitted = 1'b1;
            n_lws     = (i_in_char == C_SPACE);
            s_feed    = 1'b1;
        end
    end

    // entity decoder
    assign d_char = i_cmd.replay ? rd_char : s_char;
    assign d_feed = i_cmd.replay || s_feed;
    assign upd    = (i_cmd.feed_in && s_feed) || i_cmd.rstep;

    assign m_lt   = (r_count == CW'(2)) && ({r_buf[0], r_buf[1]} == N_LT);
    assign m_gt   = (r_count == CW'(2)) && ({r_buf[0], r_buf[1]} == N_GT);
    assign m_amp  = (r_count == CW'(3)) && ({r_buf[0], r_buf[1], r_buf[2]} == N_AMP);
    assign m_quot = (r_count == CW'(4)) &&
                    ({r_buf[0], r_buf[1], r_buf[2], r_buf[3]} == N_QUOT);
    assign m_apos = (r_count == CW'(4)) &&
                    ({r_buf[0], r_buf[1], r_buf[2], r_buf[3]} == N_APOS);
    assign m_nbsp = (r_count == CW'(4)) &&
                    ({r_buf[0], r_buf[1], r_buf[2], r_buf[3]} == N_NBSP);

    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        d_gen     = 1'b0;
        d_gch     = d_char;
        d_miss    = 1'b0;
        d_we      = 1'b0;
        if (!r_pending) begin
            if (d_char == C_AMP) begin
                n_pending = 1'b1;
                n_count   = '0;
            end else begin
                d_gen = 1'b1;
            end
        end else begin
            d_we = 1'b1;
            if (d_char == C_SEMI) begin
                n_pending = 1'b0;
                n_count   = '0;
                if (m_lt) begin
                    d_gen = 1'b1;
                    d_gch = C_LT;
                end else if (m_gt) begin
                    d_gen = 1'b1;
                    d_gch = C_GT;
                end else if (m_amp) begin
                    d_gen = 1'b1;
                    d_gch = C_AMP;
                end else if (m_quot) begin
                    d_gen = 1'b1;
                    d_gch = C_QUOT;
                end else if (m_apos) begin
                    d_gen = 1'b1;
                    d_gch = C_APOS;
                end else if (m_nbsp) begin
                    d_gen = 1'b1;
                    d_gch = C_SPACE;
                end else if (!((cnt1 >= CW'(3)) && (r_buf[0] == C_HASH))) begin
                    d_miss = 1'b1;
                end
            end else if (cnt1 == CW'(ENTITY_SPAN)) begin
                d_miss = 1'b1;
            end else begin
                n_count = cnt1;
            end
            if (d_miss) begin
                n_pending = 1'b0;
                n_count   = '0;
                d_gen     = 1'b1;
                d_gch     = C_AMP;
            end
        end
    end

    // result selection
    always_comb begin
        ld      = 1'b0;
        ld_char = r_stg;
        ld_cv   = 1'b1;
        ld_de   = 1'b0;
        ld_last = 1'b0;
        if (i_cmd.feed_in) begin
            if (s_feed && d_gen && !d_miss) begin
                ld      = 1'b1;
                ld_char = d_gch;
                ld_last = 1'b1;
            end
        end else if (i_cmd.rstep) begin
            ld = d_gen;
        end else if (i_cmd.flush) begin
            ld      = 1'b1;
            ld_last = 1'b1;
        end else if (i_cmd.end_acc) begin
            ld = 1'b1;
            if (r_pending) begin
                ld_char = C_AMP;
                ld_de   = (r_count == '0);
                ld_last = (r_count == '0);
            end else begin
                ld_char = C_NUL;
                ld_cv   = 1'b0;
                ld_de   = 1'b1;
                ld_last = 1'b1;
            end
        end else if (i_cmd.estep) begin
            ld      = 1'b1;
            ld_char = rd_char;
            ld_de   = at_end;
            ld_last = at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_emitted   <= 1'b0;
            r_lws       <= 1'b0;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.feed_in) begin
                r_inside  <= n_inside;
                r_emitted <= n_emitted;
                r_lws     <= n_lws;
            end
            if (upd) begin
                r_pending <= n_pending;
                r_count   <= n_count;
            end
            if (upd && d_miss) begin
                r_idx <= '0;
                r_len <= cnt1;
            end else if (i_cmd.rstep || i_cmd.estep) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.end_acc) begin
                r_inside  <= 1'b0;
                r_emitted <= 1'b0;
                r_lws     <= 1'b0;
                r_pending <= 1'b0;
                r_count   <= '0;
                r_idx     <= '0;
                r_len     <= r_count;
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd && d_we) begin
            r_buf[r_count[IW-1:0]] <= d_char;
        end
        if (upd && d_gen && (d_miss || i_cmd.rstep)) begin
            r_stg <= d_gch;
        end
        if (ld) begin
            r_out_char <= ld_char;
            r_out_cv   <= ld_cv;
            r_out_de   <= ld_de;
            r_out_last <= ld_last;
        end
    end

    always_comb begin
        o_sts.out_free = out_free;
        o_sts.miss     = d_feed && d_miss;
        o_sts.at_end   = at_end;
        o_sts.pending  = r_pending;
        o_sts.cnt_zero = (r_count == '0);
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_out_cv;
    assign o_doc_end    = r_out_de;
    assign o_run_last   = r_out_last;

endmodule

`default_nettype wire

// ===== hdl/html_strip_entity_decode_core.sv =====
// Top level of the HTML tag strip and entity decode core.
// Depends on hsed_pkg, hsed_in_if, hsed_out_if, hsed_ctrl, hsed_dp.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------------
//  i_in    | in  | valid / ready  | req_type, in_char
//  o_out   | out | valid / ready  | out_char, char_valid, doc_end, run_last
//
// A document byte is taken in a single step. On an entity miss the held bytes
// (up to ENTITY_SPAN) are replayed through the decoder one at a time, repeated if the
// replay misses again, and then the last staged result is released.
// End of document gives its first result and then each held byte in turn.
// A full output register stalls every step; i_in.ready is low until the item is done.
// Synchronous active-low reset returns all state to the start of a document.
`timescale 1ns / 1ps
`default_nettype none

module html_strip_entity_decode_core #(
    parameter int ENTITY_SPAN = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsed_in_if.sink      i_in,
    hsed_out_if.source   o_out
);
    import hsed_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    hsed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    hsed_dp #(
        .ENTITY_SPAN (ENTITY_SPAN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_char    (i_in.in_char),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_char   (o_out.out_char),
        .o_char_valid (o_out.char_valid),
        .o_doc_end    (o_out.doc_end),
        .o_run_last   (o_out.run_last)
    );

    assign i_in.ready = in_ready;

    a_doc_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.doc_end |-> o_out.run_last)
        else $error("doc_end without run_last");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.char_valid |-> o_out.doc_end && (o_out.out_char == C_NUL))
        else $error("empty result outside end of document");

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid || o_out.ready)
        else $error("input taken while output register blocked");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.feed_in, cmd.end_acc, cmd.rstep, cmd.flush, cmd.estep}))
        else $error("more than one datapath step in a cycle");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for html_strip_entity_decode_core: streams directed and random documents
// through the core and checks every output transfer against a behavioral decoder.
// Depends on hsed_pkg, hsed_in_if, hsed_out_if and the core.
`timescale 1ns / 1ps

module tb_top;
    import hsed_pkg::*;

    localparam int ENTITY_SPAN    = 10;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        t_byte out_char;
        logic  char_valid;
        logic  doc_end;
        logic  run_last;
    } t_result;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hsed_in_if  in_if();
    hsed_out_if out_if();

    html_strip_entity_decode_core #(
        .ENTITY_SPAN(ENTITY_SPAN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // decoder state
    logic  st_in_tag;
    logic  st_emitted;
    logic  st_last_space;
    logic  st_pending;
    t_byte st_held[ENTITY_SPAN];
    int    st_count;

    t_result step_out[$];
    t_result decoded_q[$];

    int       mismatches = 0;
    int       sent_count = 0;
    int       burst_left = 0;
    int       tx_gap_max = 0;
    t_rx_mode rx_mode    = RX_ALWAYS;
    logic     hold_req   = 1'b0;
    int       stall_cycles = 0;

    string ent_names[6] = '{"lt", "gt", "amp", "quot", "apos", "nbsp"};

    function automatic void clear_decoder();
        st_in_tag     = 1'b0;
        st_emitted    = 1'b0;
        st_last_space = 1'b0;
        st_pending    = 1'b0;
        st_count      = 0;
        for (int i = 0; i < ENTITY_SPAN; i++) st_held[i] = C_NUL;
    endfunction

    function automatic void put_char(t_byte c, logic v);
        t_result r;
        r.out_char   = v ? c : C_NUL;
        r.char_valid = v;
        r.doc_end    = 1'b0;
        r.run_last   = 1'b0;
        step_out = {step_out, r};
    endfunction

    // ';' just stored: returns 1 when the entity resolves (decoded or numeric drop)
    function automatic logic close_entity();
        int          n;
        logic [31:0] key;
        t_byte       hit;
        logic        found;
        n     = st_count - 1;
        key   = '0;
        found = 1'b0;
        hit   = C_NUL;
        for (int i = 0; i < n && i < 4; i++) key = {key[23:0], st_held[i]};
        if (n == 2 && key[15:0] == "lt") begin
            found = 1'b1; hit = C_LT;
        end else if (n == 2 && key[15:0] == "gt") begin
            found = 1'b1; hit = C_GT;
        end else if (n == 3 && key[23:0] == "amp") begin
            found = 1'b1; hit = C_AMP;
        end else if (n == 4 && key == "quot") begin
            found = 1'b1; hit = C_QUOT;
        end else if (n == 4 && key == "apos") begin
            found = 1'b1; hit = C_APOS;
        end else if (n == 4 && key == "nbsp") begin
            found = 1'b1; hit = C_SPACE;
        end
        if (found) begin
            put_char(hit, 1'b1);
            st_pending = 1'b0;
            st_count   = 0;
            return 1'b1;
        end
        if (st_count >= 3 && st_held[0] == C_HASH) begin
            st_pending = 1'b0;
            st_count   = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // on a miss the held bytes go back in front of whatever is still queued
    function automatic void decode_byte(t_byte first);
        t_byte feed_q[$];
        t_byte c;
        logic  miss;
        feed_q = {feed_q, first};
        while (feed_q.size() > 0) begin
            c    = feed_q.pop_front();
            miss = 1'b0;
            if (!st_pending) begin
                if (c == C_AMP) begin
                    st_pending = 1'b1;
                    st_count   = 0;
                end else begin
                    put_char(c, 1'b1);
                end
            end else if (st_count >= ENTITY_SPAN) begin
                feed_q.push_front(c);
                miss = 1'b1;
            end else begin
                st_held[st_count] = c;
                st_count++;
                if (c == C_SEMI) miss = !close_entity();
                else if (st_count >= ENTITY_SPAN) miss = 1'b1;
            end
            if (miss) begin
                put_char(C_AMP, 1'b1);
                for (int i = st_count - 1; i >= 0; i--) feed_q.push_front(st_held[i]);
                st_pending = 1'b0;
                st_count   = 0;
            end
        end
    endfunction

    function automatic void strip_byte(t_byte c);
        if (c == C_LT) begin
            st_in_tag = 1'b1;
        end else if (c == C_GT) begin
            st_in_tag = 1'b0;
            if (st_emitted && !st_last_space) begin
                st_last_space = 1'b1;
                decode_byte(C_SPACE);
            end
        end else if (!st_in_tag) begin
            st_emitted    = 1'b1;
            st_last_space = (c == C_SPACE);
            decode_byte(c);
        end
    endfunction

    function automatic void predict_decode(logic req, t_byte c);
        t_result r;
        step_out.delete();
        if (req == REQ_END) begin
            if (st_pending) begin
                put_char(C_AMP, 1'b1);
                for (int i = 0; i < st_count; i++) put_char(st_held[i], 1'b1);
            end
            if (step_out.size() == 0) put_char(C_NUL, 1'b0);
            r = step_out.pop_back();
            r.doc_end = 1'b1;
            step_out = {step_out, r};
            clear_decoder();
        end else begin
            strip_byte(c);
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.run_last = 1'b1;
            step_out = {step_out, r};
        end
        decoded_q = {decoded_q, step_out};
    endfunction

    // predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) predict_decode(in_if.req_type, in_if.in_char);
            if (out_if.valid && out_if.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected transfer: out_char %02h char_valid %0b doc_end %0b",
                           out_if.out_char, out_if.char_valid, out_if.doc_end);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (out_if.out_char !== want.out_char) begin
                        $error("out_char: expected %02h, got %02h",
                               want.out_char, out_if.out_char);
                        mismatches++;
                    end
                    if (out_if.char_valid !== want.char_valid) begin
                        $error("char_valid: expected %0b, got %0b",
                               want.char_valid, out_if.char_valid);
                        mismatches++;
                    end
                    if (out_if.doc_end !== want.doc_end) begin
                        $error("doc_end: expected %0b, got %0b", want.doc_end, out_if.doc_end);
                        mismatches++;
                    end
                    if (out_if.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, out_if.run_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // output side: stall modes plus a long hold-off on request
    initial begin : receiver
        int   hold_left;
        int   cyc;
        logic seen_req;
        hold_left    = 0;
        cyc          = 0;
        seen_req     = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req != seen_req) begin
                seen_req  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: out_if.ready <= 1'b1;
                    RX_RANDOM: out_if.ready <= ($urandom_range(99) < 65);
                    default:   out_if.ready <= ((cyc % 7) > 2);
                endcase
            end
        end
    end

    task automatic send_item(logic req, t_byte c);
        if (tx_gap_max > 0) begin
            if (burst_left == 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(tx_gap_max, 1)) @(posedge i_clk);
                burst_left = $urandom_range(24, 1);
            end
            burst_left--;
        end
        in_if.valid    <= 1'b1;
        in_if.req_type <= req;
        in_if.in_char  <= c;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(REQ_BYTE, s[i]);
    endtask

    task automatic send_end();
        send_item(REQ_END, t_byte'($urandom_range(255)));
    endtask

    // mostly well-formed markup and entities, some broken sequences and noise
    task automatic send_document_mix(int n_items);
        int    target;
        int    kind;
        t_byte b;
        string alpha;
        alpha  = "abglmnopqstu#&;;x ";
        target = sent_count + n_items;
        while (sent_count < target) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_item(REQ_BYTE, t_byte'($urandom_range(126, 32)));
            end else if (kind < 45) begin
                send_item(REQ_BYTE, C_LT);
                repeat ($urandom_range(5)) begin
                    b = t_byte'($urandom_range(126, 32));
                    send_item(REQ_BYTE, (b == C_GT) ? t_byte'("x") : b);
                end
                send_item(REQ_BYTE, C_GT);
            end else if (kind < 65) begin
                send_text({"&", ent_names[$urandom_range(5)], ";"});
            end else if (kind < 73) begin
                send_text("&#");
                repeat ($urandom_range(4)) send_item(REQ_BYTE, t_byte'(8'h30 + $urandom_range(9)));
                send_item(REQ_BYTE, C_SEMI);
            end else if (kind < 83) begin
                send_item(REQ_BYTE, C_AMP);
                repeat ($urandom_range(12)) send_item(REQ_BYTE, alpha[$urandom_range(alpha.len() - 1)]);
            end else if (kind < 90) begin
                send_item(REQ_BYTE, C_SPACE);
            end else if (kind < 97) begin
                send_item(REQ_BYTE, t_byte'($urandom_range(255)));
            end else begin
                send_end();
            end
        end
    endtask

    task automatic test_tag_strip();
        send_item(REQ_BYTE, C_GT);      // nothing emitted yet: no space
        send_text("A<x>");              // space after tag
        send_item(REQ_BYTE, C_GT);      // last emitted is space: nothing
    endtask

    task automatic test_entity_decode();
        send_text("&lt;");
        send_text("&#1;");              // numeric, dropped
        send_text("&#;");               // short numeric form, literal
        send_item(REQ_BYTE, C_AMP);     // window fills without ';'
        send_item(REQ_BYTE, 8'h00);
        send_item(REQ_BYTE, 8'hFF);
        send_text("abcdefgh");
    endtask

    task automatic test_doc_end();
        send_text("&q");
        send_end();                     // held bytes flushed literally
        send_end();                     // nothing held: empty marker
    endtask

    task automatic test_random_stream(int n_items, int gap_max, t_rx_mode mode);
        tx_gap_max = gap_max;
        burst_left = 0;
        rx_mode    = mode;
        send_document_mix(n_items);
    endtask

    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_mode    = RX_ALWAYS;
        hold_req   = ~hold_req;
        send_document_mix(60);
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.req_type = REQ_BYTE;
        in_if.in_char  = C_NUL;
        i_rst_n        = 1'b0;
        clear_decoder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tag_strip();
        test_entity_decode();
        test_doc_end();
        test_random_stream(100, 0, RX_ALWAYS);
        test_random_stream(150, 10, RX_RANDOM);
        test_backpressure();
        test_random_stream(100, 6, RX_PATTERN);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d results never arrived", decoded_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
